// ===== hw/rtl/qct_pkg.sv =====
// Shared constants, types and helpers for the quoted command tokenizer.
package qct_pkg;

  // Sizing of the line and the argument list.
  localparam int unsigned MaxArgs   = 16;
  localparam int unsigned LineBytes = 4096;
  localparam int unsigned PosW      = $clog2(LineBytes + 1);
  localparam int unsigned ArgsW     = $clog2(MaxArgs + 1);

  // Fixed field widths of a result item.
  localparam int unsigned TokW   = 12;
  localparam int unsigned IdxW   = 4;
  localparam int unsigned CountW = 5;

  // Special byte codes.
  localparam logic [7:0] ChrNul   = 8'd0;
  localparam logic [7:0] ChrTab   = 8'd9;
  localparam logic [7:0] ChrLf    = 8'd10;
  localparam logic [7:0] ChrVt    = 8'd11;
  localparam logic [7:0] ChrFf    = 8'd12;
  localparam logic [7:0] ChrCr    = 8'd13;
  localparam logic [7:0] ChrSpace = 8'd32;
  localparam logic [7:0] ChrQuote = 8'd34;

  // Line status codes reported at line end.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TOO_MANY = 2'd1,
    ST_UNCLOSED = 2'd2,
    ST_TOO_LONG = 2'd3
  } status_e;

  // One result item plus a flag that says whether the byte produces one.
  typedef struct packed {
    logic              emit;
    logic              token_valid;
    logic [TokW-1:0]   token_offset;
    logic [TokW-1:0]   token_length;
    logic [IdxW-1:0]   token_index;
    logic              line_done;
    status_e           line_status;
    logic [CountW-1:0] arg_count;
  } result_t;

  // Clamp a line position to the 12-bit token fields.
  function automatic logic [TokW-1:0] sat_tok(input logic [PosW-1:0] v);
    logic [TokW-1:0] r;
    if (32'(v) > 32'((1 << TokW) - 1)) begin
      r = '1;
    end else begin
      r = TokW'(v);
    end
    return r;
  endfunction

  // Clamp the argument count to the 5-bit count field.
  function automatic logic [CountW-1:0] sat_count(input logic [ArgsW-1:0] v);
    logic [CountW-1:0] r;
    if (32'(v) > 32'((1 << CountW) - 1)) begin
      r = '1;
    end else begin
      r = CountW'(v);
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/qct_if.sv =====
// Handshake interfaces for the byte input channel and the result channel.
interface qct_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] line_byte;

  modport source (output valid, output line_byte, input ready);
  modport sink   (input valid, input line_byte, output ready);
endinterface

interface qct_result_if;
  logic                         valid;
  logic                         ready;
  logic                         token_valid;
  logic [qct_pkg::TokW-1:0]     token_offset;
  logic [qct_pkg::TokW-1:0]     token_length;
  logic [qct_pkg::IdxW-1:0]     token_index;
  logic                         line_done;
  logic [1:0]                   line_status;
  logic [qct_pkg::CountW-1:0]   arg_count;

  modport source (
    output valid, output token_valid, output token_offset, output token_length,
    output token_index, output line_done, output line_status, output arg_count,
    input ready
  );
  modport sink (
    input valid, input token_valid, input token_offset, input token_length,
    input token_index, input line_done, input line_status, input arg_count,
    output ready
  );
endinterface

// ===== hw/rtl/qct_scan.sv =====
// Scanner state and the single-pass logic that turns one byte into a result.
module qct_scan (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       byte_i,
  output qct_pkg::result_t res_o
);

  typedef enum logic [1:0] {
    MODE_GAP    = 2'd0,
    MODE_PLAIN  = 2'd1,
    MODE_QUOTED = 2'd2
  } scan_mode_e;

  scan_mode_e                   mode_q, mode_d;
  logic [qct_pkg::PosW-1:0]     pos_q, pos_d;
  logic [qct_pkg::PosW-1:0]     off_q, off_d;
  logic [qct_pkg::ArgsW-1:0]    args_q, args_d;
  qct_pkg::status_e             err_q, err_d;

  logic                         is_end;
  logic                         is_gap;
  logic                         is_quote;
  logic                         finish;
  logic                         tok;
  logic [qct_pkg::PosW:0]       off_cand;
  logic [qct_pkg::PosW-1:0]     tok_len;

  // Byte classes.
  always_comb begin
    is_end   = (byte_i == qct_pkg::ChrNul) || (byte_i == qct_pkg::ChrLf) ||
               (byte_i == qct_pkg::ChrCr);
    is_gap   = (byte_i == qct_pkg::ChrTab) || (byte_i == qct_pkg::ChrVt) ||
               (byte_i == qct_pkg::ChrFf) || (byte_i == qct_pkg::ChrSpace);
    is_quote = (byte_i == qct_pkg::ChrQuote);
  end

  assign tok_len = pos_q - off_q;

  // Next state and result for the byte in hand.
  always_comb begin
    mode_d   = mode_q;
    pos_d    = pos_q;
    off_d    = off_q;
    err_d    = err_q;
    finish   = 1'b0;
    tok      = 1'b0;
    off_cand = {1'b0, off_q};

    // An ordinary byte past the line limit marks the line too long.
    if (!is_end && (pos_q >= qct_pkg::PosW'(qct_pkg::LineBytes)) &&
        (err_q == qct_pkg::ST_OK)) begin
      err_d = qct_pkg::ST_TOO_LONG;
    end

    case (mode_q)
      MODE_PLAIN: begin
        if (is_end || is_gap) begin
          finish = 1'b1;
          mode_d = MODE_GAP;
        end
      end
      MODE_QUOTED: begin
        if (is_end) begin
          if (err_d == qct_pkg::ST_OK) begin
            err_d = qct_pkg::ST_UNCLOSED;
          end
        end else if (is_quote) begin
          finish = 1'b1;
          mode_d = MODE_GAP;
        end
      end
      default: begin
        // Between tokens; the unused mode code behaves the same way.
        mode_d = MODE_GAP;
        if (!is_end && !is_gap) begin
          if (is_quote) begin
            mode_d   = MODE_QUOTED;
            off_cand = {1'b0, pos_q} + 1'b1;
          end else begin
            mode_d   = MODE_PLAIN;
            off_cand = {1'b0, pos_q};
          end
        end
      end
    endcase

    // With no error set, a finished token is reported while below MaxArgs.
    if (finish && (err_d == qct_pkg::ST_OK)) begin
      if (args_q >= qct_pkg::ArgsW'(qct_pkg::MaxArgs)) begin
        err_d = qct_pkg::ST_TOO_MANY;
      end else begin
        tok = 1'b1;
      end
    end
    args_d = args_q + qct_pkg::ArgsW'(tok);

    // Position advances and saturates; the start offset never passes it.
    if (pos_q < qct_pkg::PosW'(qct_pkg::LineBytes)) begin
      pos_d = pos_q + 1'b1;
    end
    if (off_cand > {1'b0, pos_d}) begin
      off_d = pos_d;
    end else begin
      off_d = off_cand[qct_pkg::PosW-1:0];
    end

    // Result item.
    res_o              = '0;
    res_o.emit         = tok || is_end;
    res_o.token_valid  = tok;
    res_o.line_done    = is_end;
    res_o.line_status  = is_end ? err_d : qct_pkg::ST_OK;
    res_o.arg_count    = qct_pkg::sat_count(args_d);
    if (tok) begin
      res_o.token_offset = qct_pkg::sat_tok(off_q);
      res_o.token_length = qct_pkg::sat_tok(tok_len);
      res_o.token_index  = qct_pkg::IdxW'(args_q);
    end
  end

  // Scanner state; a line-ending byte clears everything.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_GAP;
      pos_q  <= '0;
      off_q  <= '0;
      args_q <= '0;
      err_q  <= qct_pkg::ST_OK;
    end else if (step_i) begin
      if (is_end) begin
        mode_q <= MODE_GAP;
        pos_q  <= '0;
        off_q  <= '0;
        args_q <= '0;
        err_q  <= qct_pkg::ST_OK;
      end else begin
        mode_q <= mode_d;
        pos_q  <= pos_d;
        off_q  <= off_d;
        args_q <= args_d;
        err_q  <= err_d;
      end
    end
  end

  // The token start never lies beyond the current position.
  a_off_le_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    off_q <= pos_q)
    else $error("token start beyond line position");

  // The argument count never exceeds the limit.
  a_args_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    args_q <= qct_pkg::ArgsW'(qct_pkg::MaxArgs))
    else $error("argument count beyond limit");

  // A line end leaves a cleared scanner behind.
  a_line_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && is_end |=> (pos_q == '0) && (args_q == '0) &&
                         (err_q == qct_pkg::ST_OK) && (mode_q == MODE_GAP))
    else $error("scanner not cleared after line end");

  // No token is reported once an error is recorded.
  a_no_tok_after_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.token_valid |-> (err_q == qct_pkg::ST_OK))
    else $error("token reported after an error");

endmodule

// ===== hw/rtl/quoted_command_tokenizer.sv =====
// Top level of the quoted command tokenizer: input register, scanner, result register.
//
//   channel  | dir | payload                                       | accepted when
//   ---------+-----+-----------------------------------------------+----------------------
//   in_if    | in  | line_byte                                     | valid && ready
//   out_if   | out | token_valid/offset/length/index, line_done,   | valid && ready
//            |     | line_status, arg_count                        |
//
// One byte per cycle while no result stalls: a byte is registered, scanned combinationally and its
// result, if any, lands in the output register.
// The scanner state updates only when the registered byte moves on.
// Reset (rst_ni low, asynchronous) empties both registers and clears the scanner.
// A stalled result holds the byte behind it; bytes with no result pass regardless.
module quoted_command_tokenizer (
  input logic           clk_i,
  input logic           rst_ni,
  qct_byte_if.sink      in_if,
  qct_result_if.source  out_if
);

  logic             in_valid_q;
  logic [7:0]       in_byte_q;
  logic             out_valid_q;
  qct_pkg::result_t out_q;
  qct_pkg::result_t res;
  logic             advance;
  logic             in_fire;

  // The registered byte moves on unless its result would meet a stalled one.
  assign advance = in_valid_q && (!res.emit || !out_valid_q || out_if.ready);
  assign in_if.ready = !in_valid_q || advance;
  assign in_fire = in_if.valid && in_if.ready;

  qct_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .byte_i (in_byte_q),
    .res_o  (res)
  );

  // Valid flags of the input and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_fire || (in_valid_q && !advance);
      if (advance && res.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_byte_q <= in_if.line_byte;
    end
    if (advance && res.emit) begin
      out_q <= res;
    end
  end

  assign out_if.valid        = out_valid_q;
  assign out_if.token_valid  = out_q.token_valid;
  assign out_if.token_offset = out_q.token_offset;
  assign out_if.token_length = out_q.token_length;
  assign out_if.token_index  = out_q.token_index;
  assign out_if.line_done    = out_q.line_done;
  assign out_if.line_status  = out_q.line_status;
  assign out_if.arg_count    = out_q.arg_count;

  // A result item in the output register is never overwritten while stalled.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_if.ready |-> !(advance && res.emit))
    else $error("stalled result overwritten");

  // Every result item holds a token or a line end.
  a_out_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.token_valid || out_q.line_done))
    else $error("empty result item");

  // A byte held in the input register waits only behind a stalled result.
  a_hold_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |-> out_valid_q && !out_if.ready && res.emit)
    else $error("input byte held without cause");

endmodule

// ===== verif/qct_result_checker.sv =====
// Result checker for the quoted command tokenizer: tracks accepted bytes, predicts and compares.
module qct_result_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  qct_byte_if         in_if,
  qct_result_if       out_if,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned token_count_o,
  output int unsigned line_count_o,
  output int unsigned err_line_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Scanner mode: between tokens, in an unquoted token or in a quoted token.
  typedef enum logic [1:0] {
    SCAN_GAP    = 2'd0,
    SCAN_PLAIN  = 2'd1,
    SCAN_QUOTED = 2'd2
  } scan_e;

  // One result item as seen on the output channel.
  typedef struct packed {
    logic                       tok_v;
    logic [qct_pkg::TokW-1:0]   off;
    logic [qct_pkg::TokW-1:0]   len;
    logic [qct_pkg::IdxW-1:0]   idx;
    logic                       done;
    qct_pkg::status_e           st;
    logic [qct_pkg::CountW-1:0] cnt;
  } line_result_t;

  // Shadow copy of the tokenizer state.
  scan_e                      scan;
  logic [qct_pkg::PosW-1:0]   pos;
  logic [qct_pkg::PosW-1:0]   tok_start;
  logic [qct_pkg::CountW-1:0] arg_total;
  qct_pkg::status_e           line_err;

  line_result_t expected_q[$];
  int unsigned  mismatches;
  int unsigned  tokens_seen;
  int unsigned  lines_seen;
  int unsigned  err_lines_seen;

  assign fail_count_o     = mismatches;
  assign pending_o        = expected_q.size();
  assign token_count_o    = tokens_seen;
  assign line_count_o     = lines_seen;
  assign err_line_count_o = err_lines_seen;

  function automatic logic [qct_pkg::TokW-1:0] clamp_tok(input logic [qct_pkg::PosW-1:0] v);
    return (v > qct_pkg::PosW'((1 << qct_pkg::TokW) - 1)) ? '1 : v[qct_pkg::TokW-1:0];
  endfunction

  function automatic bit is_blank(input logic [7:0] b);
    return b == qct_pkg::ChrTab || b == qct_pkg::ChrVt || b == qct_pkg::ChrFf ||
           b == qct_pkg::ChrSpace;
  endfunction

  function automatic string show(input line_result_t r);
    return $sformatf("tok=%0b off=%0d len=%0d idx=%0d done=%0b status=%0d count=%0d",
                     r.tok_v, r.off, r.len, r.idx, r.done, r.st, r.cnt);
  endfunction

  task automatic clear_line();
    scan      = SCAN_GAP;
    pos       = '0;
    tok_start = '0;
    arg_total = '0;
    line_err  = qct_pkg::ST_OK;
  endtask

  // Close the token that ends at the current position, unless an error blocks it.
  task automatic close_token(inout line_result_t r);
    if (line_err != qct_pkg::ST_OK) return;
    if (arg_total >= qct_pkg::MaxArgs) begin
      line_err = qct_pkg::ST_TOO_MANY;
      return;
    end
    r.tok_v = 1'b1;
    r.off   = clamp_tok(tok_start);
    r.len   = clamp_tok(pos - tok_start);
    r.idx   = arg_total[qct_pkg::IdxW-1:0];
    arg_total++;
  endtask

  // Advance the shadow state by one byte and queue the result it causes.
  task automatic predict_byte(input logic [7:0] b);
    line_result_t r;
    r = '0;
    if (b == qct_pkg::ChrNul || b == qct_pkg::ChrLf || b == qct_pkg::ChrCr) begin
      if (scan == SCAN_PLAIN) begin
        close_token(r);
      end else if (scan == SCAN_QUOTED && line_err == qct_pkg::ST_OK) begin
        line_err = qct_pkg::ST_UNCLOSED;
      end
      r.done = 1'b1;
      r.st   = line_err;
      r.cnt  = arg_total;
      expected_q.push_back(r);
      clear_line();
      return;
    end

    if (pos >= qct_pkg::LineBytes && line_err == qct_pkg::ST_OK) begin
      line_err = qct_pkg::ST_TOO_LONG;
    end

    case (scan)
      SCAN_PLAIN: begin
        if (is_blank(b)) begin
          close_token(r);
          scan = SCAN_GAP;
        end
      end
      SCAN_QUOTED: begin
        if (b == qct_pkg::ChrQuote) begin
          close_token(r);
          scan = SCAN_GAP;
        end
      end
      default: begin
        if (b == qct_pkg::ChrQuote) begin
          scan      = SCAN_QUOTED;
          tok_start = pos + 1'b1;
        end else if (!is_blank(b)) begin
          scan      = SCAN_PLAIN;
          tok_start = pos;
        end
      end
    endcase

    if (pos < qct_pkg::LineBytes) pos++;
    if (tok_start > pos) tok_start = pos;

    if (r.tok_v) begin
      r.cnt = arg_total;
      expected_q.push_back(r);
    end
  endtask

  // Compare one accepted result with the oldest expectation.
  task automatic check_result();
    line_result_t want;
    line_result_t got;
    got.tok_v = out_if.token_valid;
    got.off   = out_if.token_offset;
    got.len   = out_if.token_length;
    got.idx   = out_if.token_index;
    got.done  = out_if.line_done;
    got.st    = qct_pkg::status_e'(out_if.line_status);
    got.cnt   = out_if.arg_count;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("[%0t] result with nothing expected: %s", $realtime, show(got));
      end
      return;
    end
    want = expected_q.pop_front();
    if (want.tok_v) tokens_seen++;
    if (want.done) begin
      lines_seen++;
      if (want.st != qct_pkg::ST_OK) err_lines_seen++;
    end
    if (got.tok_v !== want.tok_v || got.off !== want.off || got.len !== want.len ||
        got.idx !== want.idx || got.done !== want.done || got.st !== want.st ||
        got.cnt !== want.cnt) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("[%0t] result mismatch", $realtime);
        $display("  expected: %s", show(want));
        $display("  actual:   %s", show(got));
      end
    end
  endtask

  // Check results first, then account for the byte taken at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_line();
      expected_q.delete();
    end else begin
      if (out_if.valid && out_if.ready) check_result();
      if (in_if.valid && in_if.ready) predict_byte(in_if.line_byte);
    end
  end

  initial begin
    mismatches     = 0;
    tokens_seen    = 0;
    lines_seen     = 0;
    err_lines_seen = 0;
  end

endmodule

// ===== verif/tb_top.sv =====
// Testbench top for the quoted command tokenizer: clock, reset, byte stimulus and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandomBytes = 1200;
  localparam int unsigned QuietTail   = 200;
  localparam int unsigned CycleLimit  = 500000;

  logic clk_i = 1'b0;
  logic rst_ni;
  bit   idle_en;

  logic [7:0]  line_q[$];
  int unsigned random_sent;
  int unsigned cycle_cnt;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned token_count;
  int unsigned line_count;
  int unsigned err_line_count;

  qct_byte_if   byte_ch ();
  qct_result_if res_ch ();

  quoted_command_tokenizer i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (byte_ch),
    .out_if (res_ch)
  );

  qct_result_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_if            (byte_ch),
    .out_if           (res_ch),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .token_count_o    (token_count),
    .line_count_o     (line_count),
    .err_line_count_o (err_line_count)
  );

  always #2 clk_i = ~clk_i;

  // Result backpressure: random stalls while idling is enabled.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 2);
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // Cycle counter that ends a hung run.
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Timeout after %0d cycles with %0d results outstanding", cycle_cnt, pending);
    $display("Some tests failed");
    $finish;
  end

  function automatic bit is_blank(input logic [7:0] b);
    return b == qct_pkg::ChrTab || b == qct_pkg::ChrVt || b == qct_pkg::ChrFf ||
           b == qct_pkg::ChrSpace;
  endfunction

  function automatic bit is_end(input logic [7:0] b);
    return b == qct_pkg::ChrNul || b == qct_pkg::ChrLf || b == qct_pkg::ChrCr;
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 3))
      0:       return qct_pkg::ChrTab;
      1:       return qct_pkg::ChrVt;
      2:       return qct_pkg::ChrFf;
      default: return qct_pkg::ChrSpace;
    endcase
  endfunction

  function automatic logic [7:0] pick_end();
    case ($urandom_range(0, 2))
      0:       return qct_pkg::ChrNul;
      1:       return qct_pkg::ChrLf;
      default: return qct_pkg::ChrCr;
    endcase
  endfunction

  // First byte of an unquoted token: not blank, not a line end, not a quote.
  function automatic logic [7:0] pick_lead();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255));
    while (is_blank(b) || is_end(b) || b == qct_pkg::ChrQuote);
    return b;
  endfunction

  // Later bytes of an unquoted token: quotes are ordinary here.
  function automatic logic [7:0] pick_plain();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255)); while (is_blank(b) || is_end(b));
    return b;
  endfunction

  // Bytes inside quotes: blanks are kept.
  function automatic logic [7:0] pick_inner();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255)); while (is_end(b) || b == qct_pkg::ChrQuote);
    return b;
  endfunction

  task automatic push_str(input string s);
    foreach (s[i]) line_q.push_back(s[i]);
  endtask

  // Offer one item, with an optional idle gap first, and wait until it is taken.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = (idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    byte_ch.valid     <= 1'b1;
    byte_ch.line_byte <= b;
    do @(posedge clk_i); while (!byte_ch.ready);
  endtask

  task automatic send_line();
    foreach (line_q[i]) send_byte(line_q[i]);
    line_q.delete();
  endtask

  // A line of blank-separated tokens with random content, optionally ending in an unclosed quote.
  task automatic build_line(input int unsigned n_tok, input bit unclosed);
    repeat ($urandom_range(0, 2)) line_q.push_back(pick_blank());
    for (int unsigned k = 0; k < n_tok; k++) begin
      if (k > 0 && $urandom_range(0, 7) != 0) begin
        repeat ($urandom_range(1, 3)) line_q.push_back(pick_blank());
      end
      if ($urandom_range(0, 2) == 0) begin
        line_q.push_back(qct_pkg::ChrQuote);
        repeat ($urandom_range(0, 6)) line_q.push_back(pick_inner());
        line_q.push_back(qct_pkg::ChrQuote);
      end else begin
        line_q.push_back(pick_lead());
        repeat ($urandom_range(0, 7)) line_q.push_back(pick_plain());
      end
    end
    if (unclosed) begin
      line_q.push_back(pick_blank());
      line_q.push_back(qct_pkg::ChrQuote);
      repeat ($urandom_range(0, 5)) line_q.push_back(pick_inner());
    end else begin
      repeat ($urandom_range(0, 2)) line_q.push_back(pick_blank());
    end
    line_q.push_back(pick_end());
  endtask

  initial begin
    int unsigned pick;
    byte_ch.valid     = 1'b0;
    byte_ch.line_byte = '0;
    rst_ni            = 1'b0;
    idle_en           = 1'b1;
    random_sent       = 0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // Empty line.
    line_q.push_back(qct_pkg::ChrLf);
    send_line();

    // Every blank kind, a quoted token with a space, an empty quoted token,
    // a quote inside an unquoted token, and a NUL line end.
    push_str("ab");
    line_q.push_back(qct_pkg::ChrTab);
    line_q.push_back("c");
    line_q.push_back(qct_pkg::ChrVt);
    line_q.push_back("d");
    line_q.push_back(qct_pkg::ChrFf);
    push_str("e \"x y\" \"\" q\"r");
    line_q.push_back(qct_pkg::ChrNul);
    send_line();

    // Unclosed quote ended by CR.
    push_str("\"open");
    line_q.push_back(qct_pkg::ChrCr);
    send_line();

    // Extreme byte values as token content.
    line_q.push_back(8'hFF);
    line_q.push_back(qct_pkg::ChrSpace);
    line_q.push_back(8'h01);
    line_q.push_back(8'h80);
    line_q.push_back(qct_pkg::ChrLf);
    send_line();

    // More tokens than allowed, then an unclosed quote: the first error wins.
    repeat (qct_pkg::MaxArgs + 1) push_str("a ");
    push_str("\"x");
    line_q.push_back(qct_pkg::ChrLf);
    send_line();

    // Long lines run without idling to keep the run short.
    idle_en = 1'b0;

    // A token filling the whole line: its length saturates.
    repeat (qct_pkg::LineBytes) line_q.push_back("x");
    line_q.push_back(qct_pkg::ChrLf);
    send_line();

    // Line too long: bytes beyond the line size.
    repeat (qct_pkg::LineBytes + 4) line_q.push_back("x");
    line_q.push_back(qct_pkg::ChrLf);
    send_line();

    // Tokens at the largest offsets.
    repeat (qct_pkg::LineBytes - 2) line_q.push_back(qct_pkg::ChrSpace);
    push_str("zz");
    line_q.push_back(qct_pkg::ChrLf);
    send_line();
    repeat (qct_pkg::LineBytes - 1) line_q.push_back(qct_pkg::ChrSpace);
    push_str("z");
    line_q.push_back(qct_pkg::ChrCr);
    send_line();

    // Random part: mostly well-formed lines, some broken lines and noise.
    while (random_sent < RandomBytes) begin
      idle_en = (random_sent < RandomBytes - QuietTail) && ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        repeat ($urandom_range(1, 20)) line_q.push_back(8'($urandom_range(0, 255)));
      end else if (pick == 1) begin
        build_line($urandom_range(qct_pkg::MaxArgs + 1, qct_pkg::MaxArgs + 4),
                   1'($urandom_range(0, 1)));
      end else if (pick == 2) begin
        build_line($urandom_range(0, 6), 1'b1);
      end else begin
        build_line($urandom_range(0, 8), 1'b0);
      end
      random_sent += line_q.size();
      send_line();
    end

    // Close the last line in case noise left it open, then drain.
    line_q.push_back(qct_pkg::ChrLf);
    send_line();
    @(negedge clk_i);
    byte_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Covered %0d lines and %0d reported tokens; %0d lines ended with an error status.",
             line_count, token_count, err_line_count);
    $display("Mismatches: %0d, results still outstanding: %0d", fail_count, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
